>>> rtl/core/fmpc_pkg.sv
// fmpc_pkg: shared constants and types for the first-match prefix classifier
// holds the table size, field widths, the command codes and the word carried along the chain
// no dependencies
`default_nettype none

package fmpc_pkg;

	// table geometry
	localparam int TABLE_ENTRIES = 16;
	localparam int POS_W         = 8;

	// field widths
	localparam int ADDR_BITS = 32;
	localparam int LEN_W     = 6;
	localparam int IDX_W     = 4;
	localparam int TAG_W     = 16;

	// longest prefix length that is stored
	localparam logic [LEN_W-1:0] MAX_LEN = LEN_W'(ADDR_BITS);

	// command codes
	typedef enum logic {
		CMD_WRITE  = 1'b0,
		CMD_LOOKUP = 1'b1
	} cmd_t;

	// word handed from cell to cell
	typedef struct packed {
		cmd_t                 command;
		logic [IDX_W-1:0]     entry_index;
		logic                 entry_valid;
		logic [ADDR_BITS-1:0] zone_prefix;
		logic [LEN_W-1:0]     zone_length;
		logic [TAG_W-1:0]     zone_tag;
		logic [ADDR_BITS-1:0] dst_address;
		logic                 hit;
		logic [IDX_W-1:0]     match_index;
		logic [TAG_W-1:0]     match_tag;
	} word_t;

endpackage

`default_nettype wire

>>> rtl/core/first_match_prefix_classifier_unit.sv
// a request passes through the stage register of every slot cell, slot 0 first, before its response is valid
// throughput: one word per cycle while the chain is not held; each word moves one cell per cycle through the slot chain
// the whole chain holds while the response waits on rsp_stall
// reset: arst_n clears all slot valid bits and every stage valid, the table starts empty
// top level: first_match_prefix_classifier_unit, depends on fmpc_pkg and fmpc_cell
`default_nettype none

module first_match_prefix_classifier_unit
	import fmpc_pkg::*;
(
	input  wire logic                 clk,
	input  wire logic                 arst_n,
	input  wire logic                 req_valid,
	output logic                      req_stall,
	input  wire logic                 command,
	input  wire logic [IDX_W-1:0]     entry_index,
	input  wire logic                 entry_valid,
	input  wire logic [ADDR_BITS-1:0] zone_prefix,
	input  wire logic [LEN_W-1:0]     zone_length,
	input  wire logic [TAG_W-1:0]     zone_tag,
	input  wire logic [ADDR_BITS-1:0] dst_address,
	output logic                      rsp_valid,
	input  wire logic                 rsp_stall,
	output logic                      hit,
	output logic [IDX_W-1:0]          match_index,
	output logic [TAG_W-1:0]          match_tag
);

	logic                   adv;
	logic [TABLE_ENTRIES:0] chain_vld;
	word_t                  chain_word [TABLE_ENTRIES+1];
	word_t                  in_word;

	// chain moves unless the response is held
	assign adv       = !(chain_vld[TABLE_ENTRIES] && rsp_stall);
	assign req_stall = !adv;

	// incoming word, length saturated to the address width
	always_comb begin
		in_word.command     = cmd_t'(command);
		in_word.entry_index = entry_index;
		in_word.entry_valid = entry_valid;
		in_word.zone_prefix = zone_prefix;
		in_word.zone_length = (zone_length > MAX_LEN) ? MAX_LEN : zone_length;
		in_word.zone_tag    = zone_tag;
		in_word.dst_address = dst_address;
		in_word.hit         = 1'b0;
		in_word.match_index = '0;
		in_word.match_tag   = '0;
	end
	assign chain_word[0] = in_word;
	assign chain_vld[0]  = req_valid;

	// row of slot cells, slot 0 first
	for (genvar g = 0; g < TABLE_ENTRIES; g++) begin : g_cell
		fmpc_cell u_cell (
			.clk       (clk),
			.arst_n    (arst_n),
			.adv       (adv),
			.pos       (POS_W'(g)),
			.prev_vld  (chain_vld[g]),
			.prev_word (chain_word[g]),
			.word_vld  (chain_vld[g+1]),
			.word      (chain_word[g+1])
		);
	end

	// response from the last cell
	assign rsp_valid   = chain_vld[TABLE_ENTRIES];
	assign hit         = chain_word[TABLE_ENTRIES].hit;
	assign match_index = chain_word[TABLE_ENTRIES].match_index;
	assign match_tag   = chain_word[TABLE_ENTRIES].match_tag;

`ifndef SYNTH
	// a miss or a write reports zero slot and tag
	a_miss_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(rsp_valid && !hit) |-> (match_index == '0 && match_tag == '0))
		else $error("miss with nonzero index or tag");

	// a held chain keeps every stage valid bit unchanged
	a_hold_chain: assert property (@(posedge clk) disable iff (!arst_n)
		req_stall |=> $stable(chain_vld[TABLE_ENTRIES:1]))
		else $error("chain moved while held");

	// an accepted word lands in the first cell
	a_enter_first: assert property (@(posedge clk) disable iff (!arst_n)
		(req_valid && !req_stall) |=> chain_vld[1])
		else $error("accepted word lost at chain entry");
`endif

endmodule

`default_nettype wire

>>> rtl/core/fmpc_cell.sv
// fmpc_cell: one table slot of the classifier chain plus one pipeline stage
// stores a write aimed at its slot, resolves a lookup against its entry
// depends on fmpc_pkg
`default_nettype none

module fmpc_cell
	import fmpc_pkg::*;
(
	input  wire logic             clk,
	input  wire logic             arst_n,
	input  wire logic             adv,
	input  wire logic [POS_W-1:0] pos,
	input  wire logic             prev_vld,
	input  wire word_t            prev_word,
	output logic                  word_vld,
	output word_t                 word
);

	logic                 entry_valid_q;
	logic [ADDR_BITS-1:0] entry_prefix_q;
	logic [LEN_W-1:0]     entry_length_q;
	logic [TAG_W-1:0]     entry_tag_q;

	logic                 slot_sel;
	logic [ADDR_BITS-1:0] mask;
	logic                 prefix_hit;
	word_t                next_word;
	logic                 word_vld_s1;
	word_t                word_s1;

	// write targets this slot
	assign slot_sel = ({{(POS_W-IDX_W){1'b0}}, prev_word.entry_index} == pos);

	// top-length-bits mask, zero length gives an all-zero mask
	assign mask       = {ADDR_BITS{1'b1}} << (MAX_LEN - entry_length_q);
	assign prefix_hit = ((prev_word.dst_address ^ entry_prefix_q) & mask) == '0;

	// first match along the chain wins
	always_comb begin
		next_word = prev_word;
		if (prev_word.command == CMD_LOOKUP && !prev_word.hit &&
		    entry_valid_q && prefix_hit) begin
			next_word.hit         = 1'b1;
			next_word.match_index = pos[IDX_W-1:0];
			next_word.match_tag   = entry_tag_q;
		end
	end

	// entry valid bit
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			entry_valid_q <= 1'b0;
		end else if (adv && prev_vld && prev_word.command == CMD_WRITE && slot_sel) begin
			entry_valid_q <= prev_word.entry_valid;
		end
	end

	// entry payload
	always_ff @(posedge clk) begin
		if (adv && prev_vld && prev_word.command == CMD_WRITE && slot_sel) begin
			entry_prefix_q <= prev_word.zone_prefix;
			entry_length_q <= prev_word.zone_length;
			entry_tag_q    <= prev_word.zone_tag;
		end
	end

	// stage valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			word_vld_s1 <= 1'b0;
		end else if (adv) begin
			word_vld_s1 <= prev_vld;
		end
	end

	// stage payload
	always_ff @(posedge clk) begin
		if (adv) begin
			word_s1 <= next_word;
		end
	end

	assign word_vld = word_vld_s1;
	assign word     = word_s1;

endmodule

`default_nettype wire
